FILE: src/dpf_pkg.sv
// dpf_pkg: shared types and constants of the duplicate packet filter
// used by dpf_ring, dpf_ctrl and duplicate_packet_filter_top; no dependencies
`default_nettype none

package dpf_pkg;

    localparam int SRC_W    = 16;
    localparam int SEQ_W    = 32;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 32;

    // result status codes
    localparam logic [STATUS_W-1:0] ST_NEW     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd1;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd2;

    // one ring entry: source identifier and sequence number
    typedef struct packed {
        logic [SRC_W-1:0] src;
        logic [SEQ_W-1:0] seq;
    } t_entry;

    // memory port strobes from the sequencer to the ring
    typedef struct packed {
        logic rd_en;
        logic wr_en;
    } t_ring_ctl;

endpackage

`default_nettype wire

FILE: src/dpf_ring.sv
// dpf_ring: ring memory of recent (source, sequence) pairs with per-entry valid bits
// depends on dpf_pkg
`default_nettype none

module dpf_ring import dpf_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire t_ring_ctl     i_ctl,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire t_entry        i_wr_data,
    output t_entry             o_rd_data
);

    t_entry r_mem [DEPTH];
    logic   r_vld [DEPTH];
    t_entry r_rd_data;
    logic   r_rd_vld;

    // storage array, registered read
    always_ff @(posedge i_clk) begin
        if (i_ctl.wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_ctl.rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits, cleared at reset so unwritten entries read as zero
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) begin
                r_vld[k] <= 1'b0;
            end
            r_rd_vld <= 1'b0;
        end else begin
            if (i_ctl.wr_en) begin
                r_vld[i_wr_addr] <= 1'b1;
            end
            if (i_ctl.rd_en) begin
                r_rd_vld <= r_vld[i_rd_addr];
            end
        end
    end

    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

FILE: src/dpf_ctrl.sv
// dpf_ctrl: scan sequencer, write pointer, accepted counter and output register
// depends on dpf_pkg; drives the ports of dpf_ring
`default_nettype none

module dpf_ctrl import dpf_pkg::*; #(
    parameter int DEPTH = 32,
    parameter int AW    = 5,
    parameter int CW    = 6
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [SRC_W-1:0]    i_source_id,
    input  wire logic [SEQ_W-1:0]    i_seq,
    input  wire logic                i_frame_valid,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [COUNT_W-1:0]       o_accepted_count,
    output t_ring_ctl                o_ctl,
    output logic [AW-1:0]            o_rd_addr,
    output logic [AW-1:0]            o_wr_addr,
    output t_entry                   o_wr_data,
    input  wire t_entry              i_rd_data
);

    localparam logic [1:0] S_IDLE   = 2'd0;
    localparam logic [1:0] S_SCAN   = 2'd1;
    localparam logic [1:0] S_COMMIT = 2'd2;

    logic [1:0]          r_state, n_state;
    logic [CW-1:0]       r_addr, n_addr;
    logic                r_cmp, n_cmp;
    logic                r_hit, n_hit;
    logic                r_fvalid, n_fvalid;
    t_entry              r_key, n_key;
    logic [AW-1:0]       r_ptr, n_ptr;
    logic [COUNT_W-1:0]  r_total, n_total;
    logic                r_out_valid, n_out_valid;
    logic [STATUS_W-1:0] r_out_status, n_out_status;
    logic [COUNT_W-1:0]  r_out_count, n_out_count;
    logic                out_free;
    logic                match;

    assign out_free = !r_out_valid || i_ready;
    assign match    = (i_rd_data == r_key);

    // sequencer: accept, scan every entry for a valid frame, then commit the result
    always_comb begin
        n_state      = r_state;
        n_addr       = r_addr;
        n_cmp        = 1'b0;
        n_hit        = r_hit;
        n_fvalid     = r_fvalid;
        n_key        = r_key;
        n_ptr        = r_ptr;
        n_total      = r_total;
        n_out_valid  = r_out_valid;
        n_out_status = r_out_status;
        n_out_count  = r_out_count;
        o_ctl        = '0;

        if (r_out_valid && i_ready) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    n_key.src = i_source_id;
                    n_key.seq = i_seq;
                    n_fvalid  = i_frame_valid;
                    n_hit     = 1'b0;
                    n_addr    = '0;
                    n_state   = i_frame_valid ? S_SCAN : S_COMMIT;
                end
            end
            S_SCAN: begin
                if (r_addr != CW'(DEPTH)) begin
                    o_ctl.rd_en = 1'b1;
                    n_cmp       = 1'b1;
                    n_addr      = r_addr + 1'b1;
                end
                if (r_cmp && match) begin
                    n_hit = 1'b1;
                end
                if (r_addr == CW'(DEPTH) && !r_cmp) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                    if (!r_fvalid) begin
                        n_out_status = ST_INVALID;
                        n_out_count  = r_total;
                    end else if (r_hit) begin
                        n_out_status = ST_DUP;
                        n_out_count  = r_total;
                    end else begin
                        o_ctl.wr_en  = 1'b1;
                        n_ptr        = (r_ptr == AW'(DEPTH - 1)) ? '0 : r_ptr + 1'b1;
                        n_total      = r_total + 1'b1;
                        n_out_status = ST_NEW;
                        n_out_count  = r_total + 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_addr      <= '0;
            r_cmp       <= 1'b0;
            r_hit       <= 1'b0;
            r_ptr       <= '0;
            r_total     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_addr      <= n_addr;
            r_cmp       <= n_cmp;
            r_hit       <= n_hit;
            r_ptr       <= n_ptr;
            r_total     <= n_total;
            r_out_valid <= n_out_valid;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_fvalid     <= n_fvalid;
        r_key        <= n_key;
        r_out_status <= n_out_status;
        r_out_count  <= n_out_count;
    end

    assign o_ready          = (r_state == S_IDLE);
    assign o_valid          = r_out_valid;
    assign o_status         = r_out_status;
    assign o_accepted_count = r_out_count;
    assign o_rd_addr        = r_addr[AW-1:0];
    assign o_wr_addr        = r_ptr;
    assign o_wr_data        = r_key;

`ifndef NO_ASSERTIONS
    a_accept_starts_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_SCAN || r_state == S_COMMIT))
        else $error("accepted item did not start a scan or commit");

    a_total_only_on_new: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_total != $past(r_total)) |-> (r_out_valid && r_out_status == ST_NEW))
        else $error("accepted counter moved without a new-packet result");

    a_addr_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_addr <= CW'(DEPTH))
        else $error("scan address beyond ring depth");

    a_hit_from_scan: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_hit) |-> $past(r_state) == S_SCAN)
        else $error("hit flag set outside a scan");
`endif

endmodule

`default_nettype wire

FILE: src/duplicate_packet_filter_top.sv
// duplicate_packet_filter_top: duplicate packet filter over a ring of recent pairs
// depends on dpf_pkg, dpf_ring and dpf_ctrl
//
// Input channel (i_valid / o_ready) carries one item per frame: source id,
// sequence number and the upstream frame check flag. Output channel
// (o_valid / i_ready) returns one item per input: status (new, duplicate,
// invalid) and the accepted-packet count after that frame.
// A valid frame is looked up by reading the ring memory one entry per cycle;
// an invalid frame skips the lookup. One item is worked on at a time; o_ready
// is high only while the sequencer is idle, so a new item is accepted only
// after the last one has committed its result.
// The result sits in an output register, so the next item is accepted while it
// waits; if the receiver stalls, a later item waits in its commit step and the
// ring and counter are not updated until the result can be loaded.
// Reset (synchronous, active low) clears the per-entry valid bits, so every
// ring entry reads as (0,0), and zeroes the write pointer and the counter.
// No clearing pass is needed; the block is ready in the cycle after reset.
`default_nettype none

module duplicate_packet_filter_top import dpf_pkg::*; #(
    parameter int CACHE_DEPTH = 32
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_valid,
    output logic                     o_ready,
    input  wire logic [SRC_W-1:0]    i_source_id,
    input  wire logic [SEQ_W-1:0]    i_seq,
    input  wire logic                i_frame_valid,
    output logic                     o_valid,
    input  wire logic                i_ready,
    output logic [STATUS_W-1:0]      o_status,
    output logic [COUNT_W-1:0]       o_accepted_count
);

    localparam int AW = (CACHE_DEPTH > 1) ? $clog2(CACHE_DEPTH) : 1;
    localparam int CW = $clog2(CACHE_DEPTH + 1);

    t_ring_ctl     ring_ctl;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    t_entry        wr_data;
    t_entry        rd_data;

    // sequencer and result register
    dpf_ctrl #(
        .DEPTH (CACHE_DEPTH),
        .AW    (AW),
        .CW    (CW)
    ) u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_ready          (o_ready),
        .i_source_id      (i_source_id),
        .i_seq            (i_seq),
        .i_frame_valid    (i_frame_valid),
        .o_valid          (o_valid),
        .i_ready          (i_ready),
        .o_status         (o_status),
        .o_accepted_count (o_accepted_count),
        .o_ctl            (ring_ctl),
        .o_rd_addr        (rd_addr),
        .o_wr_addr        (wr_addr),
        .o_wr_data        (wr_data),
        .i_rd_data        (rd_data)
    );

    // ring memory of recent pairs
    dpf_ring #(
        .DEPTH (CACHE_DEPTH),
        .AW    (AW)
    ) u_ring (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_ctl     (ring_ctl),
        .i_rd_addr (rd_addr),
        .i_wr_addr (wr_addr),
        .i_wr_data (wr_data),
        .o_rd_data (rd_data)
    );

endmodule

`default_nettype wire
